@@ rtl/rc5_pkg.sv @@
// Shared types, constants and rotate helpers for the RC5-32 block cipher.
// Depends on nothing; rc5_round, rc5_block_cipher and the testbench import it.
`default_nettype none

package rc5_pkg;

    localparam int MAX_ROUNDS = 16;
    localparam int KEY_DEPTH  = 2 * (MAX_ROUNDS + 1);
    localparam int ROW_DEPTH  = MAX_ROUNDS + 1;
    localparam int ROW_W      = $clog2(ROW_DEPTH);
    localparam int IDX_W      = 6;
    localparam int RCNT_W     = 5;

    localparam logic [1:0] FUNC_LOAD    = 2'd0;
    localparam logic [1:0] FUNC_ENCRYPT = 2'd1;
    localparam logic [1:0] FUNC_DECRYPT = 2'd2;

    localparam logic [RCNT_W-1:0] RCNT_RESET = RCNT_W'(16);
    localparam logic [RCNT_W-1:0] RCNT_12    = RCNT_W'(12);
    localparam logic [RCNT_W-1:0] RCNT_16    = RCNT_W'(16);
    localparam logic [RCNT_W-1:0] RCNT_8     = RCNT_W'(8);

    typedef logic [31:0] word_t;

    typedef struct packed {
        logic decrypt;
        logic whiten;
    } step_ctl_t;

    function automatic logic [RCNT_W-1:0] active_rounds(input logic [RCNT_W-1:0] rc);
        logic [RCNT_W-1:0] r;
        if (rc == RCNT_12)
            r = RCNT_12;
        else if (rc == RCNT_16)
            r = RCNT_16;
        else
            r = RCNT_8;
        if (r > RCNT_W'(MAX_ROUNDS))
            r = RCNT_W'(MAX_ROUNDS);
        return r;
    endfunction

    function automatic word_t rol32(input word_t x, input logic [4:0] n);
        logic [63:0] t;
        t = {x, x} << n;
        return t[63:32];
    endfunction

    function automatic word_t ror32(input word_t x, input logic [4:0] n);
        logic [63:0] t;
        t = {x, x} >> n;
        return t[31:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/rc5_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; used for both round-key banks.
`default_nettype none

module rc5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 17
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [WIDTH-1:0]          wdata,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/rc5_round.sv @@
// One RC5-32 step: a full encrypt or decrypt round, or the key whitening.
// Depends on rc5_pkg for the rotate helpers and the control struct.
`default_nettype none

module rc5_round (
    input  rc5_pkg::step_ctl_t ctl,
    input  rc5_pkg::word_t     a_in,
    input  rc5_pkg::word_t     b_in,
    input  rc5_pkg::word_t     k_even,
    input  rc5_pkg::word_t     k_odd,
    output rc5_pkg::word_t     a_out,
    output rc5_pkg::word_t     b_out
);
    import rc5_pkg::*;

    word_t a_enc;
    word_t b_enc;
    word_t a_dec;
    word_t b_dec;

    always_comb
    begin
        a_enc = rol32(a_in ^ b_in, b_in[4:0]) + k_even;
        b_enc = rol32(b_in ^ a_enc, a_enc[4:0]) + k_odd;
        b_dec = ror32(b_in - k_odd, a_in[4:0]) ^ a_in;
        a_dec = ror32(a_in - k_even, b_dec[4:0]) ^ b_dec;

        unique case ({ctl.decrypt, ctl.whiten})
            2'b01:
            begin
                a_out = a_in + k_even;
                b_out = b_in + k_odd;
            end
            2'b11:
            begin
                a_out = a_in - k_even;
                b_out = b_in - k_odd;
            end
            2'b10:
            begin
                a_out = a_dec;
                b_out = b_dec;
            end
            default:
            begin
                a_out = a_enc;
                b_out = b_enc;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/rc5_block_cipher.sv @@
// Top level of the RC5-32 block cipher: stream ports, sequencer, key banks.
// Depends on rc5_pkg, rc5_ram and rc5_round.
`default_nettype none

// RC5-32 encrypt/decrypt engine over a table of 34 expanded round-key words.
// The table lives in two synchronous RAMs of 17 rows each: even-indexed words
// in one, odd-indexed words in the other, so row i delivers the key pair of
// round i in a single read. Each input transaction carries func in tuser
// (0 load, 1 encrypt, 2 decrypt). A load writes one word and goes to DONE with
// a zero result; the input is ready again once DONE has moved that result into
// the output register. A load with key_index of 34 or more writes nothing.
// Encrypt and decrypt read one key row per cycle and apply one full round per
// cycle: r + 1 steps (whitening plus r rounds), then DONE moves the result into
// the output register once that register is free, and only then is the next
// input transaction accepted. Here r = 8, 12 or 16 from round_count: 12 and
// 16 select themselves, any other value selects 8. round_count is written over
// the cfg channel; the user must write it only while idle, as the block itself
// does not enforce this.
// One item is processed at a time. The result sits in an output register, and
// the next input transaction is accepted while that result still waits to be
// taken; a finished item then waits until the output register is free.
// Every key word must be loaded before any cipher item reads it.
module rc5_block_cipher (
    input  wire          clk,
    input  wire          rst_n,
    // Input stream.
    input  wire          s_tvalid,
    output logic         s_tready,
    // tdata from bit 0 up: key_index[5:0], key_word[37:6], block_a[69:38],
    // block_b[101:70], zero padding[103:102].
    input  wire [103:0]  s_tdata,
    // tuser: func[1:0].
    input  wire [1:0]    s_tuser,
    // Output stream.
    output logic         m_tvalid,
    input  wire          m_tready,
    // tdata from bit 0 up: out_a[31:0], out_b[63:32].
    output logic [63:0]  m_tdata,
    // Configuration: round_count.
    input  wire          cfg_valid,
    output logic         cfg_ready,
    input  wire [4:0]    cfg_data
);
    import rc5_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [ROW_W-1:0]  ctr_reg, ctr_next;
    logic              decrypt_reg, decrypt_next;
    word_t             a_reg, a_next;
    word_t             b_reg, b_next;
    logic              out_valid_reg, out_valid_next;
    word_t             out_a_reg, out_a_next;
    word_t             out_b_reg, out_b_next;
    logic [RCNT_W-1:0] round_count_reg;

    logic [IDX_W-1:0]  in_key_index;
    word_t             in_key_word;
    word_t             in_block_a;
    word_t             in_block_b;
    logic [1:0]        in_func;

    logic              in_accept;
    logic [RCNT_W-1:0] rounds;
    logic [ROW_W-1:0]  rounds_row;
    logic [ROW_W-1:0]  rd_row;
    logic              wr_ok;
    logic              we_even;
    logic              we_odd;
    word_t             k_even;
    word_t             k_odd;
    step_ctl_t         step_ctl;
    word_t             a_step;
    word_t             b_step;
    logic              last_step;
    logic              out_free;

    assign in_key_index = s_tdata[5:0];
    assign in_key_word  = s_tdata[37:6];
    assign in_block_a   = s_tdata[69:38];
    assign in_block_b   = s_tdata[101:70];
    assign in_func      = s_tuser;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign rounds     = active_rounds(round_count_reg);
    assign rounds_row = ROW_W'(rounds);

    // Loads are written at the accepting edge; a cipher item cannot be
    // accepted until the load has gone through DONE, so a key read never
    // overlaps the write that feeds it.
    assign wr_ok   = in_accept && (in_func == FUNC_LOAD)
                     && (in_key_index < IDX_W'(KEY_DEPTH));
    assign we_even = wr_ok && !in_key_index[0];
    assign we_odd  = wr_ok && in_key_index[0];

    assign out_free = !out_valid_reg || m_tready;

    // Read address for the row needed in the following cycle.
    always_comb
    begin
        if (state_reg == ST_IDLE)
            rd_row = (in_func == FUNC_DECRYPT) ? rounds_row : '0;
        else if (state_reg == ST_RUN)
            rd_row = decrypt_reg ? (ctr_reg - 1'b1) : (ctr_reg + 1'b1);
        else
            rd_row = ctr_reg;
    end

    rc5_ram #(
        .WIDTH (32),
        .DEPTH (ROW_DEPTH)
    ) u_keys_even (
        .clk   (clk),
        .we    (we_even),
        .waddr (in_key_index[ROW_W:1]),
        .wdata (in_key_word),
        .raddr (rd_row),
        .rdata (k_even)
    );

    rc5_ram #(
        .WIDTH (32),
        .DEPTH (ROW_DEPTH)
    ) u_keys_odd (
        .clk   (clk),
        .we    (we_odd),
        .waddr (in_key_index[ROW_W:1]),
        .wdata (in_key_word),
        .raddr (rd_row),
        .rdata (k_odd)
    );

    // Row zero is whitening in both directions: first for encryption,
    // last for decryption.
    assign step_ctl.decrypt = decrypt_reg;
    assign step_ctl.whiten  = (ctr_reg == '0);

    rc5_round u_round (
        .ctl    (step_ctl),
        .a_in   (a_reg),
        .b_in   (b_reg),
        .k_even (k_even),
        .k_odd  (k_odd),
        .a_out  (a_step),
        .b_out  (b_step)
    );

    assign last_step = decrypt_reg ? (ctr_reg == '0) : (ctr_reg == rounds_row);

    always_comb
    begin
        state_next     = state_reg;
        ctr_next       = ctr_reg;
        decrypt_next   = decrypt_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        out_valid_next = out_valid_reg;
        out_a_next     = out_a_reg;
        out_b_next     = out_b_reg;

        if (m_tvalid && m_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    decrypt_next = (in_func == FUNC_DECRYPT);
                    a_next       = in_block_a;
                    b_next       = in_block_b;
                    ctr_next     = rd_row;
                    if (in_func == FUNC_ENCRYPT || in_func == FUNC_DECRYPT)
                    begin
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        a_next     = '0;
                        b_next     = '0;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_RUN:
            begin
                a_next   = a_step;
                b_next   = b_step;
                ctr_next = rd_row;
                if (last_step)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_a_next     = a_reg;
                    out_b_next     = b_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            round_count_reg <= RCNT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                round_count_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        ctr_reg     <= ctr_next;
        decrypt_reg <= decrypt_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        out_a_reg   <= out_a_next;
        out_b_reg   <= out_b_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_b_reg, out_a_reg};

    // The round counter never walks past the selected round count.
    a_ctr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (ctr_reg <= rounds_row))
        else $error("round counter out of range");

    // A load or unused func skips the rounds and goes straight to DONE.
    a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_func != FUNC_ENCRYPT && in_func != FUNC_DECRYPT)
        |=> (state_reg == ST_DONE))
        else $error("non-cipher item did not finish at once");

    // Leaving DONE always presents a result and frees the input side.
    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free) |=> (m_tvalid && state_reg == ST_IDLE))
        else $error("result not delivered from DONE");

    // A cipher item ends in DONE after its last key row.
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && last_step) |=> (state_reg == ST_DONE))
        else $error("cipher item did not finish after last round");

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for the RC5-32 block cipher (rc5_block_cipher).
// Depends on rc5_pkg and the block's RTL; it predicts each result on its own
// and checks every output transaction against that prediction.
`default_nettype none

module tb;
    import rc5_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_AFTER     = 320;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_ITEMS    = 172;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        logic [1:0]       func;
        logic [IDX_W-1:0] key_index;
        word_t            key_word;
        word_t            block_a;
        word_t            block_b;
    } cipher_item_t;

    typedef struct {
        word_t out_a;
        word_t out_b;
    } cipher_block_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [4:0]   cfg_data = '0;

    // Predictor state: our own copy of the round-key table and round setting.
    word_t             key_table [KEY_DEPTH];
    logic [RCNT_W-1:0] round_sel = RCNT_RESET;

    cipher_item_t  pending_items[$];
    cipher_block_t expected_blocks[$];

    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    bit          quiet = 1'b0;
    int unsigned idle_cycles = 0;
    int unsigned inputs_taken = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned cfg_writes = 0;
    int unsigned n_encrypt = 0;
    int unsigned n_decrypt = 0;
    int unsigned n_load = 0;
    int unsigned n_other = 0;

    rc5_block_cipher i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic word_t rotl(input word_t x, input logic [4:0] n);
        if (n == 5'd0)
            return x;
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic word_t rotr(input word_t x, input logic [4:0] n);
        if (n == 5'd0)
            return x;
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic int rounds_for(input logic [RCNT_W-1:0] rc);
        int r;
        if (rc == RCNT_12)
            r = 12;
        else if (rc == RCNT_16)
            r = 16;
        else
            r = 8;
        if (r > MAX_ROUNDS)
            r = MAX_ROUNDS;
        return r;
    endfunction

    // Works out the result of one item and applies any table write it makes.
    function automatic cipher_block_t cipher_result(input cipher_item_t it);
        cipher_block_t res;
        word_t         a;
        word_t         b;
        int            nr;
        int            i;
        a  = it.block_a;
        b  = it.block_b;
        nr = rounds_for(round_sel);
        case (it.func)
            FUNC_ENCRYPT:
            begin
                a = a + key_table[0];
                b = b + key_table[1];
                for (i = 1; i <= nr; i++)
                begin
                    a = rotl(a ^ b, b[4:0]) + key_table[2 * i];
                    b = rotl(b ^ a, a[4:0]) + key_table[2 * i + 1];
                end
            end
            FUNC_DECRYPT:
            begin
                for (i = nr; i >= 1; i--)
                begin
                    b = rotr(b - key_table[2 * i + 1], a[4:0]) ^ a;
                    a = rotr(a - key_table[2 * i], b[4:0]) ^ b;
                end
                a = a - key_table[0];
                b = b - key_table[1];
            end
            default:
            begin
                if (it.func == FUNC_LOAD && it.key_index < KEY_DEPTH)
                    key_table[it.key_index] = it.key_word;
                a = '0;
                b = '0;
            end
        endcase
        res.out_a = a;
        res.out_b = b;
        return res;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 85)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic cipher_item_t rand_item();
        cipher_item_t it;
        int unsigned  p;
        p = $urandom_range(0, 99);
        it.key_index = IDX_W'($urandom_range(0, 63));
        it.key_word  = $urandom();
        it.block_a   = $urandom();
        it.block_b   = $urandom();
        if (p < 42)
            it.func = FUNC_ENCRYPT;
        else if (p < 84)
            it.func = FUNC_DECRYPT;
        else if (p < 95)
        begin
            // Loads mostly hit the table; some land past its end.
            it.func = FUNC_LOAD;
            if ($urandom_range(0, 4) != 0)
                it.key_index = IDX_W'($urandom_range(0, KEY_DEPTH - 1));
            else
                it.key_index = IDX_W'($urandom_range(KEY_DEPTH, 63));
        end
        else
            it.func = FUNC_UNUSED;
        return it;
    endfunction

    task automatic add_item(input logic [1:0] func, input int idx, input word_t kw,
                            input word_t a, input word_t b);
        cipher_item_t it;
        it.func      = func;
        it.key_index = IDX_W'(idx);
        it.key_word  = kw;
        it.block_a   = a;
        it.block_b   = b;
        pending_items.push_back(it);
    endtask

    task automatic write_rounds(input logic [4:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        round_sel = value;
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_tvalid || expected_blocks.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Driver: offers queued items, predicting each one as it is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                cipher_item_t taken;
                taken.func      = s_tuser;
                taken.key_index = s_tdata[5:0];
                taken.key_word  = s_tdata[37:6];
                taken.block_a   = s_tdata[69:38];
                taken.block_b   = s_tdata[101:70];
                expected_blocks.push_back(cipher_result(taken));
                inputs_taken <= inputs_taken + 1;
                case (taken.func)
                    FUNC_ENCRYPT: n_encrypt++;
                    FUNC_DECRYPT: n_decrypt++;
                    FUNC_LOAD:    n_load++;
                    default:      n_other++;
                endcase
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left != 0)
                begin
                    s_tvalid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_items.size() != 0)
                begin
                    s_tdata  <= {2'b00, pending_items[0].block_b, pending_items[0].block_a,
                                 pending_items[0].key_word, pending_items[0].key_index};
                    s_tuser  <= pending_items[0].func;
                    s_tvalid <= 1'b1;
                    gap_left <= quiet ? 0 : pick_gap();
                    pending_items.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // One long receiver hold-off, counted here, so the block backs up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && inputs_taken >= HOLD_AFTER)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else if (hold_left != 0)
            m_tready <= 1'b0;
        else if (stall_left != 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 3) == 0)
                stall_left <= pick_gap();
        end
    end

    // Monitor: each output transaction is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen <= results_seen + 1;
            if (expected_blocks.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("ERROR: result a=%08h b=%08h arrived with nothing expected",
                             m_tdata[31:0], m_tdata[63:32]);
            end
            else
            begin
                if (m_tdata[31:0] !== expected_blocks[0].out_a
                    || m_tdata[63:32] !== expected_blocks[0].out_b)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("ERROR: result %0d expected a=%08h b=%08h, got a=%08h b=%08h",
                                 results_seen, expected_blocks[0].out_a,
                                 expected_blocks[0].out_b, m_tdata[31:0], m_tdata[63:32]);
                end
                expected_blocks.pop_front();
            end
        end
    end

    // Watchdog: ends the run if no transaction of any kind happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("ERROR: no transaction for %0d cycles, %0d results still expected",
                     idle_cycles, expected_blocks.size());
            $display("Regression FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        logic [4:0] settings [7];
        int         p;
        int         n;
        settings = '{5'd12, 5'd8, 5'd0, 5'd31, 5'd16, 5'd17, 5'd12};
        foreach (key_table[k])
            key_table[k] = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset setting of 16 rounds. The whole table is
        // loaded first, so no cipher item ever reads a word that was not written.
        write_rounds(RCNT_16);
        for (n = 0; n < KEY_DEPTH; n++)
            add_item(FUNC_LOAD, n, $urandom(), $urandom(), $urandom());
        add_item(FUNC_LOAD, 0, 32'h0000_0000, '0, '0);
        add_item(FUNC_LOAD, KEY_DEPTH - 1, 32'hFFFF_FFFF, '0, '0);
        add_item(FUNC_ENCRYPT, 0, '0, 32'h0000_0000, 32'h0000_0000);
        add_item(FUNC_ENCRYPT, 63, '1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_item(FUNC_ENCRYPT, 0, '0, 32'h0000_0000, 32'hFFFF_FFFF);
        add_item(FUNC_ENCRYPT, 0, '0, 32'h8000_0000, 32'h0000_0001);
        add_item(FUNC_DECRYPT, 0, '0, 32'h0000_0000, 32'h0000_0000);
        add_item(FUNC_DECRYPT, 63, '1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_item(FUNC_DECRYPT, 0, '0, 32'hFFFF_FFFF, 32'h0000_0000);
        add_item(FUNC_DECRYPT, 0, '0, 32'h0000_001F, 32'h8000_0000);
        // Loads past the end of the table write nothing but still return zero.
        add_item(FUNC_LOAD, KEY_DEPTH, 32'hFFFF_FFFF, '1, '1);
        add_item(FUNC_LOAD, 63, 32'hDEAD_BEEF, '0, '0);
        // The unused function code changes nothing.
        add_item(FUNC_UNUSED, 63, '1, '1, '1);
        add_item(FUNC_UNUSED, 0, '0, '0, '0);
        add_item(FUNC_ENCRYPT, 0, '0, $urandom(), $urandom());
        add_item(FUNC_DECRYPT, 0, '0, $urandom(), $urandom());
        wait_drained();

        // Random phases, each under its own round setting. Every other phase
        // runs without random gaps or stalls on either side.
        for (p = 0; p < 7; p++)
        begin
            quiet = p[0];
            write_rounds(settings[p]);
            for (n = 0; n < PHASE_ITEMS; n++)
                pending_items.push_back(rand_item());
            wait_drained();
        end

        repeat (20) @(posedge clk);
        $display("Covered %0d encrypt, %0d decrypt, %0d load and %0d unused-code items",
                 n_encrypt, n_decrypt, n_load, n_other);
        $display("over %0d round settings; %0d results checked, %0d mismatches",
                 cfg_writes, results_seen, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
